/* rtl/vfcm_pkg.sv */
// shared types, constants and corner table of the voxel face culling mesher
package vfcm_pkg;

  localparam int SIZE_X   = 16;
  localparam int SIZE_Y   = 256;
  localparam int SIZE_Z   = 16;
  localparam int TEX_BITS = 16;

  localparam int VOXELS = SIZE_X * SIZE_Y * SIZE_Z;
  localparam int ADDR_W = $clog2(VOXELS);
  localparam int CNT_W  = 21;
  localparam int NUM_FACES = 6;

  localparam int IN_W   = 72;
  localparam int USER_W = 2;
  localparam int OUT_W  = 64;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_MESH  = 2'd1,
    OP_CLEAR = 2'd2
  } opcode_t;

  localparam logic [2:0] FACE_TOP    = 3'd0;
  localparam logic [2:0] FACE_BOTTOM = 3'd1;
  localparam logic [2:0] FACE_FRONT  = 3'd2;
  localparam logic [2:0] FACE_REAR   = 3'd3;
  localparam logic [2:0] FACE_MX     = 3'd4;
  localparam logic [2:0] FACE_PX     = 3'd5;

  // memory read selects: center voxel, then one neighbor per face
  localparam logic [2:0] SEL_CENTER = 3'd0;
  localparam logic [2:0] SEL_TOP    = 3'd1;
  localparam logic [2:0] SEL_BOTTOM = 3'd2;
  localparam logic [2:0] SEL_FRONT  = 3'd3;
  localparam logic [2:0] SEL_REAR   = 3'd4;
  localparam logic [2:0] SEL_MX     = 3'd5;
  localparam logic [2:0] SEL_PX     = 3'd6;

  localparam logic [1:0] CORNER_LAST = 2'd3;

  typedef struct packed {
    logic [6:0]  pad;
    logic [15:0] side_tex;
    logic [15:0] bottom_tex;
    logic [15:0] top_tex;
    logic        opaque;
    logic [3:0]  pos_z;
    logic [7:0]  pos_y;
    logic [3:0]  pos_x;
  } item_t;

  typedef struct packed {
    logic                opaque;
    logic [TEX_BITS-1:0] top_tex;
    logic [TEX_BITS-1:0] bottom_tex;
    logic [TEX_BITS-1:0] side_tex;
  } voxel_t;

  typedef struct packed {
    logic [2:0]       pad;
    logic [CNT_W-1:0] vertex_number;
    logic             tex_v;
    logic             tex_u;
    logic [15:0]      tex_id;
    logic [2:0]       face_code;
    logic [4:0]       vert_z;
    logic [8:0]       vert_y;
    logic [4:0]       vert_x;
  } vert_t;

  typedef struct packed {
    logic       load;
    logic       wr;
    logic       clr;
    logic       rd;
    logic [2:0] rd_sel;
    logic       emit;
    logic [1:0] corner;
  } cmd_t;

  typedef struct packed {
    logic in_range;
    logic ctr_opaque;
    logic vis_any;
    logic last_face;
    logic out_free;
  } stat_t;

  // corner offsets {dx,dy,dz}, corner 0 in the low bits
  function automatic logic [2:0] corner_ofs(input logic [2:0] face, input logic [1:0] k);
    logic [11:0] row;
    row = '0;
    case (face)
      FACE_TOP:    row = 12'b111_011_010_110;
      FACE_BOTTOM: row = 12'b100_000_001_101;
      FACE_FRONT:  row = 12'b011_111_101_001;
      FACE_REAR:   row = 12'b110_010_000_100;
      FACE_MX:     row = 12'b010_011_001_000;
      FACE_PX:     row = 12'b111_110_100_101;
      default:     row = '0;
    endcase
    return row[3*k +: 3];
  endfunction

endpackage

/* rtl/vfcm_ctrl.sv */
// sequencing state machine of the voxel face culling mesher
module vfcm_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic [1:0]      in_opcode,
  input  vfcm_pkg::stat_t stat,
  output logic            in_ready,
  output vfcm_pkg::cmd_t  cmd
);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_READ  = 5'b00010,
    ST_WAIT  = 5'b00100,
    ST_CHECK = 5'b01000,
    ST_EMIT  = 5'b10000
  } state_t;

  state_t     state_r, state_nxt;
  logic [2:0] sel_r, sel_nxt;
  logic [1:0] corner_r, corner_nxt;

  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt  = state_r;
    sel_nxt    = sel_r;
    corner_nxt = corner_r;
    cmd        = '0;
    cmd.rd_sel = sel_r;
    cmd.corner = corner_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          case (in_opcode)
            vfcm_pkg::OP_WRITE: begin
              cmd.wr = stat.in_range;
            end
            vfcm_pkg::OP_MESH: begin
              if (stat.in_range) begin
                state_nxt = ST_READ;
                sel_nxt   = vfcm_pkg::SEL_CENTER;
              end
            end
            vfcm_pkg::OP_CLEAR: begin
              cmd.clr = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end
      ST_READ: begin
        cmd.rd = 1'b1;
        if (sel_r == vfcm_pkg::SEL_PX) begin
          state_nxt = ST_WAIT;
        end else begin
          sel_nxt = sel_r + 3'd1;
        end
      end
      // last neighbor word still on its way out of the memory
      ST_WAIT: begin
        state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        if (stat.ctr_opaque && stat.vis_any) begin
          state_nxt  = ST_EMIT;
          corner_nxt = 2'd0;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          corner_nxt = corner_r + 2'd1;
          if (corner_r == vfcm_pkg::CORNER_LAST && stat.last_face) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      sel_r    <= vfcm_pkg::SEL_CENTER;
      corner_r <= 2'd0;
    end else begin
      state_r  <= state_nxt;
      sel_r    <= sel_nxt;
      corner_r <= corner_nxt;
    end
  end

endmodule

/* rtl/vfcm_datapath.sv */
// voxel memory, neighbor visibility, vertex counter and output register
module vfcm_datapath (
  input  logic            clk,
  input  logic            rst_n,
  input  vfcm_pkg::item_t item,
  input  vfcm_pkg::cmd_t  cmd,
  output vfcm_pkg::stat_t stat,
  output logic            out_valid,
  output vfcm_pkg::vert_t out_vert,
  output logic            out_last,
  input  logic            out_ready
);

  localparam int AW = vfcm_pkg::ADDR_W;

  vfcm_pkg::voxel_t mem [vfcm_pkg::VOXELS];
  vfcm_pkg::voxel_t rdata_r;
  vfcm_pkg::voxel_t center_r;
  vfcm_pkg::voxel_t wdata;

  logic [3:0]    pos_x_r;
  logic [7:0]    pos_y_r;
  logic [3:0]    pos_z_r;
  logic [AW-1:0] addr_r;
  logic [5:0]    nbv_r;

  logic          in_range;
  logic [AW-1:0] item_addr;
  logic [5:0]    item_nbv;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] mem_addr;

  logic       rd_pend_r;
  logic [2:0] rd_sel_r;
  logic [2:0] nb_idx;
  logic [5:0] vis_r;
  logic [2:0] cur_face;
  logic       last_face;
  logic [2:0] ofs;
  logic [15:0] tex;

  logic                       out_valid_r;
  logic                       out_last_r;
  vfcm_pkg::vert_t            out_vert_r;
  logic [vfcm_pkg::CNT_W-1:0] cnt_r;

  assign in_range = (32'(item.pos_x) < vfcm_pkg::SIZE_X) &&
                    (32'(item.pos_y) < vfcm_pkg::SIZE_Y) &&
                    (32'(item.pos_z) < vfcm_pkg::SIZE_Z);

  assign item_addr = AW'(32'(item.pos_x) + 32'(item.pos_z) * vfcm_pkg::SIZE_X +
                         32'(item.pos_y) * (vfcm_pkg::SIZE_X * vfcm_pkg::SIZE_Z));

  // neighbor inside the grid, one bit per face
  assign item_nbv[vfcm_pkg::FACE_TOP]    = (32'(item.pos_y) + 32'd1) < vfcm_pkg::SIZE_Y;
  assign item_nbv[vfcm_pkg::FACE_BOTTOM] = (item.pos_y != 8'd0);
  assign item_nbv[vfcm_pkg::FACE_FRONT]  = (32'(item.pos_z) + 32'd1) < vfcm_pkg::SIZE_Z;
  assign item_nbv[vfcm_pkg::FACE_REAR]   = (item.pos_z != 4'd0);
  assign item_nbv[vfcm_pkg::FACE_MX]     = (item.pos_x != 4'd0);
  assign item_nbv[vfcm_pkg::FACE_PX]     = (32'(item.pos_x) + 32'd1) < vfcm_pkg::SIZE_X;

  assign wdata.opaque     = item.opaque;
  assign wdata.top_tex    = item.top_tex[vfcm_pkg::TEX_BITS-1:0];
  assign wdata.bottom_tex = item.bottom_tex[vfcm_pkg::TEX_BITS-1:0];
  assign wdata.side_tex   = item.side_tex[vfcm_pkg::TEX_BITS-1:0];

  always_comb begin
    case (cmd.rd_sel)
      vfcm_pkg::SEL_CENTER: rd_addr = addr_r;
      vfcm_pkg::SEL_TOP:    rd_addr = addr_r + AW'(vfcm_pkg::SIZE_X * vfcm_pkg::SIZE_Z);
      vfcm_pkg::SEL_BOTTOM: rd_addr = addr_r - AW'(vfcm_pkg::SIZE_X * vfcm_pkg::SIZE_Z);
      vfcm_pkg::SEL_FRONT:  rd_addr = addr_r + AW'(vfcm_pkg::SIZE_X);
      vfcm_pkg::SEL_REAR:   rd_addr = addr_r - AW'(vfcm_pkg::SIZE_X);
      vfcm_pkg::SEL_MX:     rd_addr = addr_r - AW'(1);
      vfcm_pkg::SEL_PX:     rd_addr = addr_r + AW'(1);
      default:              rd_addr = addr_r;
    endcase
  end

  // single port: writes only happen in the accept cycle, reads only afterwards
  assign mem_addr = cmd.wr ? item_addr : rd_addr;

  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      mem[mem_addr] <= wdata;
    end
    if (cmd.rd) begin
      rdata_r <= mem[mem_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pos_x_r <= item.pos_x;
      pos_y_r <= item.pos_y;
      pos_z_r <= item.pos_z;
      addr_r  <= item_addr;
      nbv_r   <= item_nbv;
    end
  end

  assign nb_idx = rd_sel_r - 3'd1;

  always_comb begin
    cur_face = vfcm_pkg::FACE_TOP;
    for (int i = vfcm_pkg::NUM_FACES - 1; i >= 0; i--) begin
      if (vis_r[i]) begin
        cur_face = 3'(i);
      end
    end
  end

  assign last_face = ((vis_r & (vis_r - 6'd1)) == 6'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_pend_r <= 1'b0;
      rd_sel_r  <= vfcm_pkg::SEL_CENTER;
      vis_r     <= '0;
    end else begin
      rd_pend_r <= cmd.rd;
      rd_sel_r  <= cmd.rd_sel;
      if (rd_pend_r && rd_sel_r != vfcm_pkg::SEL_CENTER) begin
        vis_r[nb_idx] <= !(nbv_r[nb_idx] && rdata_r.opaque);
      end
      if (cmd.emit && cmd.corner == vfcm_pkg::CORNER_LAST) begin
        vis_r[cur_face] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_pend_r && rd_sel_r == vfcm_pkg::SEL_CENTER) begin
      center_r <= rdata_r;
    end
  end

  assign ofs = vfcm_pkg::corner_ofs(cur_face, cmd.corner);

  always_comb begin
    case (cur_face)
      vfcm_pkg::FACE_TOP:    tex = 16'(center_r.top_tex);
      vfcm_pkg::FACE_BOTTOM: tex = 16'(center_r.bottom_tex);
      default:               tex = 16'(center_r.side_tex);
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cmd.clr) begin
        cnt_r <= '0;
      end else if (cmd.emit) begin
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_vert_r.pad           <= '0;
      out_vert_r.vert_x        <= 5'(pos_x_r) + 5'(ofs[2]);
      out_vert_r.vert_y        <= 9'(pos_y_r) + 9'(ofs[1]);
      out_vert_r.vert_z        <= 5'(pos_z_r) + 5'(ofs[0]);
      out_vert_r.face_code     <= cur_face;
      out_vert_r.tex_id        <= tex;
      out_vert_r.tex_u         <= (cmd.corner == 2'd1) || (cmd.corner == 2'd2);
      out_vert_r.tex_v         <= cmd.corner[1];
      out_vert_r.vertex_number <= cnt_r;
      out_last_r               <= (cmd.corner == vfcm_pkg::CORNER_LAST) && last_face;
    end
  end

  assign stat.in_range   = in_range;
  assign stat.ctr_opaque = center_r.opaque;
  assign stat.vis_any    = |vis_r;
  assign stat.last_face  = last_face;
  assign stat.out_free   = !out_valid_r || out_ready;

  assign out_valid = out_valid_r;
  assign out_vert  = out_vert_r;
  assign out_last  = out_last_r;

endmodule

/* rtl/voxel_face_culling_mesher.sv */
// top level of the voxel face culling mesher
//
//  channel | dir | handshake            | contents
//  --------+-----+----------------------+------------------------------------------
//  in_     | in  | in_tvalid/in_tready  | write, mesh or clear request, opcode in tuser
//  out_    | out | out_tvalid/out_tready| one vertex, 64 bits, tlast on final vertex
//
// write and clear requests are done in the accept cycle. a mesh request first makes
// seven reads of the single-port voxel memory for its lookups and then emits one
// vertex per cycle while the output is free, four per visible face. synchronous
// reset clears control and the vertex counter; the voxel memory is not cleared. a
// stalled output holds the vertex in its register and the burst waits; a new
// request is taken while the final vertex of the previous one is still waiting.
module voxel_face_culling_mesher (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  // pos_x, pos_y, pos_z, opaque, top_tex, bottom_tex, side_tex, zero pad
  input  logic [vfcm_pkg::IN_W-1:0]   in_tdata,
  // opcode
  input  logic [vfcm_pkg::USER_W-1:0] in_tuser,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  // vert_x, vert_y, vert_z, face_code, tex_id, tex_u, tex_v, vertex_number, zero pad
  output logic [vfcm_pkg::OUT_W-1:0]  out_tdata,
  output logic                        out_tlast
);

  vfcm_pkg::item_t item;
  vfcm_pkg::cmd_t  cmd;
  vfcm_pkg::stat_t stat;
  vfcm_pkg::vert_t out_vert;

  assign item = vfcm_pkg::item_t'(in_tdata);

  vfcm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_opcode (in_tuser),
    .stat      (stat),
    .in_ready  (in_tready),
    .cmd       (cmd)
  );

  vfcm_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .item      (item),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_tvalid),
    .out_vert  (out_vert),
    .out_last  (out_tlast),
    .out_ready (out_tready)
  );

  assign out_tdata = out_vert;

endmodule

/* rtl/vfcm_checker.sv */
// port-level checks of the voxel face culling mesher and their bind
module vfcm_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_tready,
  input logic                       out_tvalid,
  input logic                       out_tready,
  input logic [vfcm_pkg::OUT_W-1:0] out_tdata,
  input logic                       out_tlast
);

  vfcm_pkg::vert_t            vert;
  logic [vfcm_pkg::CNT_W-1:0] vnum;

  assign vert = vfcm_pkg::vert_t'(out_tdata);
  assign vnum = vert.vertex_number;

  // no vertex survives a reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  // a vertex appears only while the input side is closed for the burst
  a_burst_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(!in_tready))
    else $error("vertex emitted while input was open");

  // inside a burst the next vertex follows with the next number
  a_number_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast |=>
      !out_tvalid || (vnum == $past(vnum) + 1'b1))
    else $error("vertex number did not step inside a burst");

  // stalled vertex holds
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled vertex changed");

endmodule

bind voxel_face_culling_mesher vfcm_checker u_vfcm_checker (.*);
